// ----- src/dmd_pkg.sv -----
// shared constants for the differential motor drive: field widths, config codes,
// the tangent table behind the wheel ratio ROM and the reciprocal constants
// no dependencies
package dmd_pkg;

    localparam int ANGLE_W         = 8;
    localparam int SPEED_W         = 8;
    localparam int DUTY_W          = 16;
    localparam int PERIOD_W        = 16;
    localparam int SWITCH_W        = 4;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 16;

    localparam int ANGLE_TABLE_SIZE = 46;
    localparam int ROM_ENTRIES      = 46;
    localparam int RATIO_FRAC_BITS  = 16;
    localparam int RATIO_W          = RATIO_FRAC_BITS + 1;
    localparam int IDX_W            = $clog2(ROM_ENTRIES);
    localparam int IDX_LAST         = ((ANGLE_TABLE_SIZE < ROM_ENTRIES) ?
                                       ANGLE_TABLE_SIZE : ROM_ENTRIES) - 1;

    localparam longint unsigned HALF_BASE_X2 = 42;
    localparam longint unsigned TRACK_WIDTH  = 17;
    localparam longint unsigned MICRO        = 1000000;

    localparam int CMD_LIMIT    = 100;
    localparam int CMD_MAG_W    = 7;
    localparam int SCALE_OFFSET = 5;

    // x / 20 = (x >> 2) / 5, and y / 5 = (y * 838861) >> 22 exactly for y < 2^22
    localparam int         DIV5_MUL_W = 20;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 20'd838861;
    localparam int         DIV5_SHIFT = 22;

    // x / 100 = (x >> 2) / 25, and y / 25 = (y * 2684355) >> 26 exactly for y < 2^21
    localparam int         DIV25_MUL_W = 22;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 22'd2684355;
    localparam int         DIV25_SHIFT = 26;

    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET   = 16'd40000;
    localparam logic [SWITCH_W-1:0] SPEED_SWITCH_RESET = 4'd15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PWM_PERIOD   = 1'b0,
        CFG_SPEED_SWITCH = 1'b1
    } cfg_index_t;

    // tan(k degrees) in units of 1e-6
    localparam logic [31:0] TAN_MICRO [ROM_ENTRIES] = '{
        32'd0,      32'd17455,  32'd34921,  32'd52408,  32'd69927,  32'd87489,
        32'd105104, 32'd122785, 32'd140541, 32'd158384, 32'd176327,
        32'd194380, 32'd212557, 32'd230868, 32'd249328, 32'd267949,
        32'd286745, 32'd305731, 32'd324920, 32'd344328, 32'd363970,
        32'd383864, 32'd404026, 32'd424475, 32'd445229, 32'd466308,
        32'd487733, 32'd509525, 32'd531709, 32'd554309, 32'd577350,
        32'd600861, 32'd624869, 32'd649408, 32'd674509, 32'd700208,
        32'd726543, 32'd753554, 32'd781286, 32'd809784, 32'd839100,
        32'd869287, 32'd900404, 32'd932515, 32'd965689, 32'd1000000
    };

endpackage

// ----- src/differential_motor_drive.sv -----
// differential motor drive: one command accepted every cycle, busy never rises
// since the pipeline cannot be stalled
// stages: angle/ROM lookup, ratio multiply and clamp, duty multiply, divide by 100
// max duty is rebuilt from the config registers via cfg_prod_reg and max_duty_reg after a write
// rst_n (async, active low) clears the valid bits and loads the register defaults
// depends on dmd_pkg
module differential_motor_drive (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [dmd_pkg::ANGLE_W-1:0] steer_angle,
    input  logic signed [dmd_pkg::SPEED_W-1:0] outer_speed,
    output logic                               done,
    output logic [dmd_pkg::DUTY_W-1:0]         left_duty,
    output logic                               left_reverse,
    output logic [dmd_pkg::DUTY_W-1:0]         right_duty,
    output logic                               right_reverse,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmd_pkg::*;

    localparam int CAP_MAG_W  = SPEED_W;
    localparam int SCALE_W    = SWITCH_W + 1;
    localparam int CFG_PROD_W = PERIOD_W + SCALE_W;
    localparam int Q5_W       = CFG_PROD_W - 2;
    localparam int DUTY_PROD_W = DUTY_W + CMD_MAG_W;
    localparam int Q25_W      = DUTY_PROD_W - 2;

    // ratio ROM, worked out at elaboration
    logic [RATIO_W-1:0] ratio_rom [ROM_ENTRIES];

    for (genvar k = 0; k < ROM_ENTRIES; k++) begin : g_rom
        localparam longint unsigned TW  = TRACK_WIDTH * longint'(TAN_MICRO[k]);
        localparam longint unsigned NUM = (HALF_BASE_X2 * MICRO - TW) << RATIO_FRAC_BITS;
        localparam longint unsigned DEN = HALF_BASE_X2 * MICRO + TW;
        localparam longint unsigned RATIO = NUM / DEN;
        assign ratio_rom[k] = RATIO[RATIO_W-1:0];
    end

    // configuration
    logic [PERIOD_W-1:0]   pwm_period_reg;
    logic [SWITCH_W-1:0]   speed_switch_reg;
    logic [CFG_PROD_W-1:0] cfg_prod_reg, cfg_prod_next;
    logic [DUTY_W-1:0]     max_duty_reg, max_duty_next;
    logic [Q5_W+DIV5_MUL_W-1:0] max_mul;
    logic [PERIOD_W-1:0]   period_m1;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg   <= PWM_PERIOD_RESET;
            speed_switch_reg <= SPEED_SWITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_SPEED_SWITCH: speed_switch_reg <= cfg_data[SWITCH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        // a zero period acts as one
        period_m1     = (pwm_period_reg == '0) ? '0 : pwm_period_reg - 1'b1;
        cfg_prod_next = CFG_PROD_W'(period_m1) *
                        CFG_PROD_W'(SCALE_W'(speed_switch_reg) + SCALE_W'(SCALE_OFFSET));
        max_mul       = (Q5_W + DIV5_MUL_W)'(cfg_prod_reg[CFG_PROD_W-1:2]) *
                        (Q5_W + DIV5_MUL_W)'(DIV5_MUL);
        max_duty_next = max_mul[DIV5_SHIFT +: DUTY_W];
    end

    always_ff @(posedge clk)
    begin
        cfg_prod_reg <= cfg_prod_next;
        max_duty_reg <= max_duty_next;
    end

    // stage 1: index, cap and ROM lookup
    logic                 v1_reg;
    logic [RATIO_W-1:0]   ratio_reg, ratio_next;
    logic [CAP_MAG_W-1:0] cap_mag_reg, cap_mag_next;
    logic                 cap_neg_reg, cap_neg_next;
    logic [CAP_MAG_W-1:0] outer_mag_reg, outer_mag_next;
    logic                 outer_neg_reg;
    logic                 right_inner_reg, right_inner_next;
    logic [ANGLE_W-1:0]   angle_abs;
    logic [IDX_W-1:0]     idx;
    logic signed [SPEED_W-1:0] cap;

    always_comb
    begin
        angle_abs = steer_angle[ANGLE_W-1] ? ANGLE_W'(-steer_angle) : steer_angle;
        idx = (angle_abs > ANGLE_W'(IDX_LAST)) ? IDX_W'(IDX_LAST) : angle_abs[IDX_W-1:0];
        cap = (outer_speed > SPEED_W'(CMD_LIMIT)) ? SPEED_W'(CMD_LIMIT) : outer_speed;
        cap_neg_next   = cap[SPEED_W-1];
        cap_mag_next   = cap_neg_next ? CAP_MAG_W'(-cap) : cap;
        outer_mag_next = outer_speed[SPEED_W-1] ? CAP_MAG_W'(-outer_speed) : outer_speed;
        ratio_next     = ratio_rom[idx];
        right_inner_next = !steer_angle[ANGLE_W-1] && (steer_angle != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ratio_reg       <= ratio_next;
        cap_mag_reg     <= cap_mag_next;
        cap_neg_reg     <= cap_neg_next;
        outer_mag_reg   <= outer_mag_next;
        outer_neg_reg   <= outer_speed[SPEED_W-1];
        right_inner_reg <= right_inner_next;
    end

    // stage 2: inner speed, clamp, wheel assignment
    logic                   v2_reg;
    logic [CMD_MAG_W-1:0]   left_mag_reg, left_mag_next, right_mag_reg, right_mag_next;
    logic                   left_rev_reg, left_rev_next, right_rev_reg, right_rev_next;
    logic [CAP_MAG_W+RATIO_W-1:0] inner_prod;
    logic [CAP_MAG_W-1:0]   inner_raw;
    logic [CMD_MAG_W-1:0]   inner_mag, outer_mag;
    logic                   inner_rev;

    always_comb
    begin
        inner_prod = (CAP_MAG_W + RATIO_W)'(cap_mag_reg) * (CAP_MAG_W + RATIO_W)'(ratio_reg);
        inner_raw  = inner_prod[RATIO_FRAC_BITS +: CAP_MAG_W];
        inner_mag  = (inner_raw > CAP_MAG_W'(CMD_LIMIT)) ? CMD_MAG_W'(CMD_LIMIT)
                                                         : inner_raw[CMD_MAG_W-1:0];
        // truncation toward zero can give a zero inner speed, which is not reverse
        inner_rev  = cap_neg_reg && (inner_raw != '0);
        outer_mag  = (outer_mag_reg > CAP_MAG_W'(CMD_LIMIT)) ? CMD_MAG_W'(CMD_LIMIT)
                                                             : outer_mag_reg[CMD_MAG_W-1:0];
        if (right_inner_reg)
        begin
            left_mag_next  = outer_mag;
            left_rev_next  = outer_neg_reg;
            right_mag_next = inner_mag;
            right_rev_next = inner_rev;
        end
        else
        begin
            left_mag_next  = inner_mag;
            left_rev_next  = inner_rev;
            right_mag_next = outer_mag;
            right_rev_next = outer_neg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        left_mag_reg  <= left_mag_next;
        left_rev_reg  <= left_rev_next;
        right_mag_reg <= right_mag_next;
        right_rev_reg <= right_rev_next;
    end

    // stage 3: max duty times command magnitude
    logic                   v3_reg;
    logic [DUTY_PROD_W-1:0] left_prod_reg, left_prod_next, right_prod_reg, right_prod_next;
    logic                   left_rev3_reg, right_rev3_reg;

    always_comb
    begin
        left_prod_next  = DUTY_PROD_W'(max_duty_reg) * DUTY_PROD_W'(left_mag_reg);
        right_prod_next = DUTY_PROD_W'(max_duty_reg) * DUTY_PROD_W'(right_mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        left_prod_reg  <= left_prod_next;
        right_prod_reg <= right_prod_next;
        left_rev3_reg  <= left_rev_reg;
        right_rev3_reg <= right_rev_reg;
    end

    // stage 4: divide by 100 with a reciprocal multiply
    logic                  done_reg;
    logic [DUTY_W-1:0]     left_duty_reg, left_duty_next, right_duty_reg, right_duty_next;
    logic                  left_reverse_reg, right_reverse_reg;
    logic [Q25_W+DIV25_MUL_W-1:0] left_q, right_q;

    always_comb
    begin
        left_q  = (Q25_W + DIV25_MUL_W)'(left_prod_reg[DUTY_PROD_W-1:2]) *
                  (Q25_W + DIV25_MUL_W)'(DIV25_MUL);
        right_q = (Q25_W + DIV25_MUL_W)'(right_prod_reg[DUTY_PROD_W-1:2]) *
                  (Q25_W + DIV25_MUL_W)'(DIV25_MUL);
        left_duty_next  = left_q[DIV25_SHIFT +: DUTY_W];
        right_duty_next = right_q[DIV25_SHIFT +: DUTY_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        left_duty_reg     <= left_duty_next;
        right_duty_reg    <= right_duty_next;
        left_reverse_reg  <= left_rev3_reg;
        right_reverse_reg <= right_rev3_reg;
    end

    assign done          = done_reg;
    assign left_duty     = left_duty_reg;
    assign left_reverse  = left_reverse_reg;
    assign right_duty    = right_duty_reg;
    assign right_reverse = right_reverse_reg;

endmodule

// ----- src/dmd_checker.sv -----
// port-level checks for the differential motor drive, attached by bind
// depends on dmd_pkg and differential_motor_drive
module dmd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [dmd_pkg::ANGLE_W-1:0] steer_angle,
    input logic signed [dmd_pkg::SPEED_W-1:0] outer_speed,
    input logic                               done,
    input logic [dmd_pkg::DUTY_W-1:0]         left_duty,
    input logic                               left_reverse,
    input logic [dmd_pkg::DUTY_W-1:0]         right_duty,
    input logic                               right_reverse
);
    import dmd_pkg::*;

    // every accepted transaction gives a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction without result");

    // no result without an earlier accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without transaction");

    // the inner wheel never runs faster than the outer one
    a_inner_slower: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(steer_angle, 4) > 8'sd0) ? (right_duty <= left_duty)
                                                  : (left_duty <= right_duty)))
        else $error("inner wheel duty above outer wheel duty");

    // the outer wheel direction follows the sign of the requested speed
    a_outer_dir: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(steer_angle, 4) > 8'sd0) ? (left_reverse == $past(outer_speed[7], 4))
                                                  : (right_reverse == $past(outer_speed[7], 4))))
        else $error("outer wheel direction mismatch");

endmodule

bind differential_motor_drive dmd_checker u_dmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .steer_angle  (steer_angle),
    .outer_speed  (outer_speed),
    .done         (done),
    .left_duty    (left_duty),
    .left_reverse (left_reverse),
    .right_duty   (right_duty),
    .right_reverse(right_reverse)
);

// ----- tb/tb_differential_motor_drive.sv -----
// self-checking testbench for differential_motor_drive: directed and random drive commands
// with register changes between phases, each result checked against an in-bench wheel model
// depends on dmd_pkg and differential_motor_drive
module tb_differential_motor_drive;

    import dmd_pkg::*;

    localparam int LATENCY         = 4;
    localparam int SETTLE_CYCLES   = LATENCY + 2;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 100;
    localparam int SCALE_DIV       = 20;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_COMMANDS  = 150;
    localparam int STREAM_COMMANDS = 500;

    typedef struct {
        logic [DUTY_W-1:0] left_duty;
        logic              left_reverse;
        logic [DUTY_W-1:0] right_duty;
        logic              right_reverse;
    } wheel_cmd_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ANGLE_W-1:0] steer_angle;
    logic signed [SPEED_W-1:0] outer_speed;
    logic                      done;
    logic [DUTY_W-1:0]         left_duty;
    logic                      left_reverse;
    logic [DUTY_W-1:0]         right_duty;
    logic                      right_reverse;
    logic                      cfg_valid;
    logic                      cfg_ready;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // register copies seen by the wheel model
    logic [PERIOD_W-1:0] shadow_period = PWM_PERIOD_RESET;
    logic [SWITCH_W-1:0] shadow_switch = SPEED_SWITCH_RESET;

    wheel_cmd_t expected_wheels[$];
    int  commands_accepted = 0;
    int  results_checked   = 0;
    int  mismatch_count    = 0;
    int  settings_applied  = 0;
    int  idle_cycles       = 0;
    bit  idling_on         = 1'b1;

    differential_motor_drive dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .steer_angle  (steer_angle),
        .outer_speed  (outer_speed),
        .done         (done),
        .left_duty    (left_duty),
        .left_reverse (left_reverse),
        .right_duty   (right_duty),
        .right_reverse(right_reverse),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // inner/outer speed ratio in Q16 for a table angle
    function automatic longint unsigned wheel_ratio(input int unsigned k);
        longint unsigned t;
        t = longint'(TAN_MICRO[k]) * TRACK_WIDTH;
        return ((HALF_BASE_X2 * MICRO - t) << RATIO_FRAC_BITS) / (HALF_BASE_X2 * MICRO + t);
    endfunction

    function automatic void wheel_pwm(input int cmd, input longint unsigned full_duty,
                                      output logic [DUTY_W-1:0] duty, output logic rev);
        int c;
        longint unsigned mag;
        c = (cmd > CMD_LIMIT) ? CMD_LIMIT : ((cmd < -CMD_LIMIT) ? -CMD_LIMIT : cmd);
        mag = (c < 0) ? longint'(-c) : longint'(c);
        duty = DUTY_W'((full_duty * mag) / CMD_LIMIT);
        rev = (c < 0);
    endfunction

    function automatic wheel_cmd_t predict_wheels(input logic signed [ANGLE_W-1:0] angle,
                                                  input logic signed [SPEED_W-1:0] speed);
        wheel_cmd_t w;
        int a;
        int s;
        int cap;
        int inner;
        int unsigned idx;
        longint unsigned cap_mag;
        longint unsigned prod;
        longint unsigned period;
        longint unsigned full_duty;
        a = angle;
        s = speed;
        cap = (s > CMD_LIMIT) ? CMD_LIMIT : s;
        idx = (a < 0) ? -a : a;
        if (idx > IDX_LAST)
            idx = IDX_LAST;
        cap_mag = (cap < 0) ? longint'(-cap) : longint'(cap);
        prod = (cap_mag * wheel_ratio(idx)) >> RATIO_FRAC_BITS;
        inner = (cap < 0) ? -int'(prod) : int'(prod);
        // a zero period behaves like a period of one
        period = (shadow_period == 0) ? 1 : shadow_period;
        full_duty = ((period - 1) * (shadow_switch + SCALE_OFFSET)) / SCALE_DIV;
        if (a > 0)
        begin
            wheel_pwm(s, full_duty, w.left_duty, w.left_reverse);
            wheel_pwm(inner, full_duty, w.right_duty, w.right_reverse);
        end
        else
        begin
            wheel_pwm(inner, full_duty, w.left_duty, w.left_reverse);
            wheel_pwm(s, full_duty, w.right_duty, w.right_reverse);
        end
        return w;
    endfunction

    function automatic void check_field(input string field, input logic [DUTY_W-1:0] want,
                                        input logic [DUTY_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // accepts commands, results and register writes at each edge
    always @(posedge clk)
    begin : monitor
        wheel_cmd_t want;
        bit activity;
        if (rst_n)
        begin
            activity = 1'b0;
            if (done)
            begin
                activity = 1'b1;
                results_checked++;
                if (expected_wheels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with no command outstanding, expected none, got %0d/%0d",
                                 $time, left_duty, right_duty);
                end
                else
                begin
                    want = expected_wheels.pop_front();
                    check_field("left_duty", want.left_duty, left_duty);
                    check_field("left_reverse", DUTY_W'(want.left_reverse),
                                DUTY_W'(left_reverse));
                    check_field("right_duty", want.right_duty, right_duty);
                    check_field("right_reverse", DUTY_W'(want.right_reverse),
                                DUTY_W'(right_reverse));
                end
            end
            if (start && !busy)
            begin
                activity = 1'b1;
                commands_accepted++;
                expected_wheels.push_back(predict_wheels(steer_angle, outer_speed));
            end
            if (cfg_valid && cfg_ready)
            begin
                activity = 1'b1;
                if (cfg_index == CFG_PWM_PERIOD)
                    shadow_period = cfg_data[PERIOD_W-1:0];
                else
                    shadow_switch = cfg_data[SWITCH_W-1:0];
            end
            idle_cycles = activity ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // one command transaction, with an occasional random gap before it
    task automatic issue_command(input logic signed [ANGLE_W-1:0] angle,
                                 input logic signed [SPEED_W-1:0] speed);
        int gap;
        if (idling_on && $urandom_range(0, 99) < 3)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        steer_angle <= angle;
        outer_speed <= speed;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_wheels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_settings(input logic [PERIOD_W-1:0] period,
                                  input logic [CFG_DATA_W-1:0] switch_data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_PWM_PERIOD, period);
        write_reg(CFG_SPEED_SWITCH, switch_data);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 60)
            v = int'($urandom_range(0, 100)) - 50;
        else if (r < 80)
            v = int'($urandom_range(0, 255)) - 128;
        else
        begin
            case ($urandom_range(0, 5))
                0: v = -128;
                1: v = 127;
                2: v = 45;
                3: v = -45;
                4: v = 46;
                default: v = 0;
            endcase
        end
        return ANGLE_W'(v);
    endfunction

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int v;
        if ($urandom_range(0, 99) < 70)
            v = int'($urandom_range(0, 220)) - 110;
        else
            v = int'($urandom_range(0, 255)) - 128;
        return SPEED_W'(v);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return PERIOD_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // switch writes carry random upper data bits, which the register drops
    function automatic logic [CFG_DATA_W-1:0] switch_word(input int unsigned sw);
        return (CFG_DATA_W'($urandom) & 16'hFFF0) | CFG_DATA_W'(sw);
    endfunction

    // reset register values: angle and speed extremes, table end, most negative inputs
    task automatic test_default_registers();
        int angles[14] = '{0, 0, 0, 1, -1, 45, -45, 46, -46, 127, -128, 30, -30, -128};
        int speeds[14] = '{100, 127, -128, 100, 100, 100, -100, 50, -50, 127, -128, 0, 101, -1};
        for (int i = 0; i < 14; i++)
            issue_command(ANGLE_W'(angles[i]), SPEED_W'(speeds[i]));
    endtask

    // zero period, unit period and full-scale period at both switch ends
    task automatic test_register_extremes();
        int periods[4]  = '{0, 1, 65535, 65535};
        int switches[4] = '{15, 0, 0, 15};
        for (int i = 0; i < 4; i++)
        begin
            write_settings(PERIOD_W'(periods[i]), switch_word(switches[i]));
            issue_command(8'sd10, 8'sd100);
            issue_command(-8'sd128, -8'sd128);
        end
    endtask

    task automatic test_random_traffic();
        idling_on = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_settings(pick_period(), switch_word($urandom_range(0, 15)));
            for (int i = 0; i < PHASE_COMMANDS; i++)
                issue_command(pick_angle(), pick_speed());
        end
    endtask

    // back-to-back commands with no gaps, one full drain in the middle
    task automatic test_streaming();
        idling_on = 1'b0;
        write_settings(PERIOD_W'($urandom_range(1, 65535)), switch_word($urandom_range(0, 15)));
        for (int i = 0; i < STREAM_COMMANDS; i++)
        begin
            if (i == STREAM_COMMANDS / 2)
                drain_results();
            issue_command(pick_angle(), pick_speed());
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        steer_angle = '0;
        outer_speed = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_PWM_PERIOD;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_registers();
        test_register_extremes();
        test_random_traffic();
        test_streaming();

        drain_results();
        repeat (LATENCY + 4) @(posedge clk);
        $display("covered %0d drive commands under %0d register settings, %0d results checked",
                 commands_accepted, settings_applied + 1, results_checked);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
